>>> design/perspective_attribute_interpolator_macros.svh
// Assertion macros shared by the checker files of the interpolator.
// Needs nothing else; every macro takes a clock, an active-low reset and a message.
`ifndef PERSPECTIVE_ATTRIBUTE_INTERPOLATOR_MACROS_SVH
`define PERSPECTIVE_ATTRIBUTE_INTERPOLATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PAI_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PAI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/pai_pkg.sv
// Shared constants, register codes and pipeline payload types of the interpolator.
// Has no dependencies; every other design file but the assertion macros header imports it.
package pai_pkg;

    localparam int DataW       = 32;
    localparam int WeightW     = 16;
    localparam int CoordW      = 16;
    localparam int DivSteps    = DataW;
    localparam int FrontStages = 4;
    localparam int BackStages  = 2;
    localparam int StageCount  = FrontStages + DivSteps + BackStages;
    localparam int FracSpan    = 8;
    localparam int FracEdge    = 9;
    localparam int PAddrW      = 1;
    localparam int PDataW      = 32;

    localparam logic [PAddrW-1:0]  RegPrecision = '0;
    localparam logic [WeightW-1:0] MaskSpan     = 16'h007F;
    localparam logic [WeightW-1:0] MaskEdge     = 16'h007E;

    typedef struct packed {
        logic        [DataW-1:0]   value_b;
        logic        [DataW-1:0]   value_a;
        logic signed [CoordW-1:0]  range_max;
        logic signed [CoordW-1:0]  range_min;
        logic signed [CoordW-1:0]  position;
        logic        [WeightW-1:0] weight_end;
        logic        [WeightW-1:0] weight_start;
    } t_in_s;

    typedef struct packed {
        logic [DataW-1:0]   t0;
        logic [DataW-1:0]   t1;
        logic [DataW-1:0]   den_lin;
        logic [DataW-1:0]   num_lin;
        logic [WeightW-1:0] w0n;
        logic [WeightW-1:0] w0d;
        logic [WeightW-1:0] w1d;
        logic [DataW-1:0]   value_a;
        logic [DataW-1:0]   value_b;
        logic               edge_mode;
        logic               force_lin;
    } t_prep_s;

    typedef struct packed {
        logic [DataW-1:0] num_wt;
        logic [DataW-1:0] prod_end;
        logic [DataW-1:0] prod_start;
        logic [DataW-1:0] num_lin;
        logic [DataW-1:0] den_lin;
        logic [DataW-1:0] value_a;
        logic [DataW-1:0] value_b;
        logic             edge_mode;
        logic             force_lin;
    } t_prod_s;

    typedef struct packed {
        logic [DataW-1:0] num;
        logic [DataW-1:0] rem;
        logic [DataW-1:0] den;
    } t_div_ch;

    typedef struct packed {
        t_div_ch          lin;
        t_div_ch          wt;
        logic [DataW-1:0] value_a;
        logic [DataW-1:0] value_b;
        logic             edge_mode;
        logic             force_lin;
    } t_mid_s;

    typedef struct packed {
        logic [DataW-1:0] sel_a;
        logic [DataW-1:0] sel_b;
        logic [DataW-1:0] lin_a;
        logic [DataW-1:0] lin_b;
        logic [DataW-1:0] f_lin;
        logic [DataW-1:0] f_wt;
        logic             edge_mode;
        logic             force_lin;
    } t_blend_s;

    typedef struct packed {
        logic [DataW-1:0] weighted_factor;
        logic [DataW-1:0] linear_factor;
        logic [DataW-1:0] linear_value;
        logic [DataW-1:0] blend_value;
        logic             used_linear;
    } t_out_s;

endpackage

>>> design/pai_front.sv
// Front stages: input capture, span differences, weight halving in edge mode, products, divisor sum.
// Depends on pai_pkg; feeds the first divider step.
module pai_front import pai_pkg::*; (
    input  logic                  i_clk,
    input  logic [FrontStages-1:0] i_en,
    input  t_in_s                 i_item,
    input  logic                  i_edge_mode,
    output t_mid_s                o_mid
);

    t_in_s   r_item;
    logic    r_edge;
    t_prep_s r_prep;
    t_prod_s r_prod;
    t_mid_s  r_mid;
    t_prep_s n_prep;
    t_prod_s n_prod;
    t_mid_s  n_mid;

    always_comb begin
        logic [DataW-1:0]   x32;
        logic [DataW-1:0]   xmin32;
        logic [DataW-1:0]   xmax32;
        logic [WeightW-1:0] mask;
        x32    = {{(DataW-CoordW){r_item.position[CoordW-1]}}, r_item.position};
        xmin32 = {{(DataW-CoordW){r_item.range_min[CoordW-1]}}, r_item.range_min};
        xmax32 = {{(DataW-CoordW){r_item.range_max[CoordW-1]}}, r_item.range_max};
        mask   = r_edge ? MaskEdge : MaskSpan;
        n_prep.t0        = x32 - xmin32;
        n_prep.t1        = xmax32 - x32;
        n_prep.den_lin   = xmax32 - xmin32;
        n_prep.num_lin   = r_edge ? (n_prep.t0 << FracEdge) : (n_prep.t0 << FracSpan);
        n_prep.w0n       = r_edge ? (r_item.weight_start >> 1) : r_item.weight_start;
        n_prep.w1d       = r_edge ? (r_item.weight_end >> 1) : r_item.weight_end;
        n_prep.w0d       = r_edge ? ((r_item.weight_start >> 1) +
                           WeightW'(r_item.weight_start[0] & ~r_item.weight_end[0]))
                           : r_item.weight_start;
        n_prep.value_a   = r_item.value_a;
        n_prep.value_b   = r_item.value_b;
        n_prep.edge_mode = r_edge;
        n_prep.force_lin = (r_item.weight_start == r_item.weight_end) &&
                           ((r_item.weight_start & mask) == '0);
    end

    always_comb begin
        n_prod.num_wt     = r_prep.num_lin * {{(DataW-WeightW){1'b0}}, r_prep.w0n};
        n_prod.prod_end   = r_prep.t1 * {{(DataW-WeightW){1'b0}}, r_prep.w1d};
        n_prod.prod_start = r_prep.t0 * {{(DataW-WeightW){1'b0}}, r_prep.w0d};
        n_prod.num_lin    = r_prep.num_lin;
        n_prod.den_lin    = r_prep.den_lin;
        n_prod.value_a    = r_prep.value_a;
        n_prod.value_b    = r_prep.value_b;
        n_prod.edge_mode  = r_prep.edge_mode;
        n_prod.force_lin  = r_prep.force_lin;
    end

    always_comb begin
        n_mid.lin.num   = r_prod.num_lin;
        n_mid.lin.rem   = '0;
        n_mid.lin.den   = r_prod.den_lin;
        n_mid.wt.num    = r_prod.num_wt;
        n_mid.wt.rem    = '0;
        n_mid.wt.den    = r_prod.prod_end + r_prod.prod_start;
        n_mid.value_a   = r_prod.value_a;
        n_mid.value_b   = r_prod.value_b;
        n_mid.edge_mode = r_prod.edge_mode;
        n_mid.force_lin = r_prod.force_lin;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_item <= i_item;
            r_edge <= i_edge_mode;
        end
        if (i_en[1]) begin
            r_prep <= n_prep;
        end
        if (i_en[2]) begin
            r_prod <= n_prod;
        end
        if (i_en[3]) begin
            r_mid <= n_mid;
        end
    end

    assign o_mid = r_mid;

endmodule

>>> design/pai_div_step.sv
// One registered step of the two restoring dividers, one quotient bit per channel.
// Depends on pai_pkg; chained DivSteps times in the top level.
module pai_div_step import pai_pkg::*; (
    input  logic   i_clk,
    input  logic   i_en,
    input  t_mid_s i_mid,
    output t_mid_s o_mid
);

    t_mid_s r_mid;
    t_mid_s n_mid;

    function automatic t_div_ch div_step(input t_div_ch c);
        logic [DataW:0] trial;
        logic [DataW:0] diff;
        logic           qbit;
        t_div_ch        r;
        trial = {c.rem, c.num[DataW-1]};
        diff  = trial - {1'b0, c.den};
        qbit  = (trial >= {1'b0, c.den});
        r.den = c.den;
        r.rem = qbit ? diff[DataW-1:0] : trial[DataW-1:0];
        r.num = {c.num[DataW-2:0], qbit};
        return r;
    endfunction

    always_comb begin
        n_mid     = i_mid;
        n_mid.lin = div_step(i_mid.lin);
        n_mid.wt  = div_step(i_mid.wt);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mid <= n_mid;
        end
    end

    assign o_mid = r_mid;

endmodule

>>> design/pai_back.sv
// Back stages: zero-divisor fix, factor selection, blend products, final sum and shift.
// Depends on pai_pkg; takes the quotients from the last divider step.
module pai_back import pai_pkg::*; (
    input  logic                  i_clk,
    input  logic [BackStages-1:0] i_en,
    input  t_mid_s                i_mid,
    output t_out_s                o_out
);

    t_blend_s r_blend;
    t_out_s   r_out;
    t_blend_s n_blend;
    t_out_s   n_out;

    always_comb begin
        logic [DataW-1:0] f_sel;
        logic [DataW-1:0] one;
        n_blend.f_lin     = (i_mid.lin.den == '0) ? '0 : i_mid.lin.num;
        n_blend.f_wt      = (i_mid.wt.den == '0) ? '0 : i_mid.wt.num;
        f_sel             = i_mid.force_lin ? n_blend.f_lin : n_blend.f_wt;
        one               = i_mid.edge_mode ? (DataW'(1) << FracEdge) : (DataW'(1) << FracSpan);
        n_blend.sel_a     = i_mid.value_a * (one - f_sel);
        n_blend.sel_b     = i_mid.value_b * f_sel;
        n_blend.lin_a     = i_mid.value_a * (one - n_blend.f_lin);
        n_blend.lin_b     = i_mid.value_b * n_blend.f_lin;
        n_blend.edge_mode = i_mid.edge_mode;
        n_blend.force_lin = i_mid.force_lin;
    end

    always_comb begin
        logic [DataW-1:0] sum_sel;
        logic [DataW-1:0] sum_lin;
        sum_sel               = r_blend.sel_a + r_blend.sel_b;
        sum_lin               = r_blend.lin_a + r_blend.lin_b;
        n_out.blend_value     = r_blend.edge_mode ? (sum_sel >> FracEdge) : (sum_sel >> FracSpan);
        n_out.linear_value    = r_blend.edge_mode ? (sum_lin >> FracEdge) : (sum_lin >> FracSpan);
        n_out.linear_factor   = r_blend.f_lin;
        n_out.weighted_factor = r_blend.f_wt;
        n_out.used_linear     = r_blend.force_lin;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_blend <= n_blend;
        end
        if (i_en[1]) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule

>>> design/perspective_attribute_interpolator.sv
// Perspective-correct attribute interpolator: takes one transfer per clock unless the full pipeline
// is stalled at its output, and returns one result per input through the 32 registered steps of the
// two restoring dividers plus four front and two back stages. A stage holds only while it and every
// stage after it are full and the output is stalled, so a waiting result only stops the items behind it.
// Depends on pai_pkg, pai_front, pai_div_step and pai_back.
module perspective_attribute_interpolator import pai_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PAddrW-1:0]      paddr,
    input  logic [PDataW-1:0]      pwdata,
    output logic [PDataW-1:0]      prdata,
    output logic                   pready,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // weight_start, weight_end, position, range_min, range_max, value_a, value_b
    input  logic [$bits(t_in_s)-1:0] i_s_axis_tdata,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // blend_value, linear_value, linear_factor, weighted_factor
    output logic [4*DataW-1:0]     o_m_axis_tdata,
    // used_linear
    output logic                   o_m_axis_tuser
);

    logic                  r_precision;
    logic [StageCount-1:0] r_vld;
    logic [StageCount-1:0] n_vld;
    logic [StageCount-1:0] w_en;
    t_mid_s                w_mid [DivSteps+1];
    t_out_s                w_out;

    assign pready = 1'b1;
    assign prdata = (paddr == RegPrecision) ? {{(PDataW-1){1'b0}}, r_precision} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_precision <= 1'b0;
        end else if (psel && penable && pwrite && pready && (paddr == RegPrecision)) begin
            r_precision <= pwdata[0];
        end
    end

    genvar g;
    generate
        for (g = 0; g < StageCount; g++) begin : g_en
            assign w_en[g] = i_m_axis_tready || !(&r_vld[StageCount-1:g]);
        end
    endgenerate

    assign n_vld = {r_vld[StageCount-2:0], i_s_axis_tvalid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < StageCount; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    pai_front u_front (
        .i_clk       (i_clk),
        .i_en        (w_en[FrontStages-1:0]),
        .i_item      (t_in_s'(i_s_axis_tdata)),
        .i_edge_mode (r_precision),
        .o_mid       (w_mid[0])
    );

    generate
        for (g = 0; g < DivSteps; g++) begin : g_div
            pai_div_step u_step (
                .i_clk (i_clk),
                .i_en  (w_en[FrontStages+g]),
                .i_mid (w_mid[g]),
                .o_mid (w_mid[g+1])
            );
        end
    endgenerate

    pai_back u_back (
        .i_clk (i_clk),
        .i_en  (w_en[StageCount-1 -: BackStages]),
        .i_mid (w_mid[DivSteps]),
        .o_out (w_out)
    );

    assign o_s_axis_tready = w_en[0];
    assign o_m_axis_tvalid = r_vld[StageCount-1];
    assign o_m_axis_tdata  = {w_out.weighted_factor, w_out.linear_factor,
                              w_out.linear_value, w_out.blend_value};
    assign o_m_axis_tuser  = w_out.used_linear;

endmodule

>>> design/pai_checker.sv
// Port-level checks of the interpolator, bound to the top level.
// Depends on pai_pkg and the assertion macros header.
`include "perspective_attribute_interpolator_macros.svh"

module pai_checker import pai_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     pready,
    input logic                     o_s_axis_tready,
    input logic                     o_m_axis_tvalid,
    input logic                     i_m_axis_tready,
    input logic [4*DataW-1:0]       o_m_axis_tdata,
    input logic                     o_m_axis_tuser
);

    `PAI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata), "Stalled result changed.")
    `PAI_ASSERT_SAME(a_forced_equal, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata[DataW-1:0] == o_m_axis_tdata[2*DataW-1:DataW], "Forced linear blend differs.")
    `PAI_ASSERT_SAME(a_empty_ready, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready, "Input stalled with empty output.")
    `PAI_ASSERT_SAME(a_drain_ready, i_clk, i_rst_n, o_m_axis_tvalid && i_m_axis_tready, o_s_axis_tready && pready, "Input stalled while output drains.")

endmodule

bind perspective_attribute_interpolator pai_checker u_pai_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .pready          (pready),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

>>> tb/sv/tb.sv
// Self-checking testbench for perspective_attribute_interpolator: stream traffic with random
// idling on both sides, APB writes of the precision register between batches.
// Depends on pai_pkg and the interpolator RTL.
`timescale 1ns / 1ps

module tb;
    import pai_pkg::*;

    localparam int StallLimit = 2000;
    localparam int DrainCycles = StageCount + 4;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PAddrW-1:0] paddr = '0;
    logic [PDataW-1:0] pwdata = '0;
    logic [PDataW-1:0] prdata;
    logic pready;

    logic s_valid = 1'b0;
    t_in_s s_tdata = '0;
    logic o_s_axis_tready;
    logic o_m_axis_tvalid;
    logic m_ready = 1'b0;
    logic [4*DataW-1:0] o_m_axis_tdata;
    logic o_m_axis_tuser;

    t_in_s pending_pixels[$];
    t_out_s awaited_results[$];
    logic edge_mode_cfg = 1'b0;
    logic in_done = 1'b0;
    int idle_pct = 33;
    int error_count = 0;
    int stall_cycles = 0;

    perspective_attribute_interpolator dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(s_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(o_m_axis_tdata),
        .o_m_axis_tuser(o_m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [DataW-1:0] mix_attr(logic [DataW-1:0] a, logic [DataW-1:0] b,
                                                  logic [DataW-1:0] f, int unsigned p);
        logic [DataW-1:0] one;
        logic [DataW-1:0] acc;
        one = 32'd1 << p;
        acc = a * (one - f) + b * f;
        return acc >> p;
    endfunction

    function automatic t_out_s interpolate(t_in_s px, logic edge_mode);
        logic [DataW-1:0] x, xmin, xmax, t0, t1, span, num, prod, den;
        logic [DataW-1:0] w0n, w0d, w1d, f_lin, f_wt;
        logic [WeightW-1:0] mask;
        logic force_lin;
        int unsigned p;
        t_out_s r;
        p = edge_mode ? FracEdge : FracSpan;
        x = {{16{px.position[15]}}, px.position};
        xmin = {{16{px.range_min[15]}}, px.range_min};
        xmax = {{16{px.range_max[15]}}, px.range_max};
        t0 = x - xmin;
        t1 = xmax - x;
        num = t0 << p;
        span = xmax - xmin;
        f_lin = (span != 0) ? num / span : 32'd0;
        w0n = {16'd0, px.weight_start};
        w0d = w0n;
        w1d = {16'd0, px.weight_end};
        if (edge_mode) begin
            w0n = w0n >> 1;
            w0d = w0d >> 1;
            w1d = w1d >> 1;
            if (px.weight_start[0] && !px.weight_end[0]) begin
                w0d = w0d + 32'd1;
            end
        end
        prod = num * w0n;
        den = t1 * w1d + t0 * w0d;
        f_wt = (den != 0) ? prod / den : 32'd0;
        mask = edge_mode ? MaskEdge : MaskSpan;
        force_lin = (px.weight_start == px.weight_end) && ((px.weight_start & mask) == '0);
        r.blend_value = mix_attr(px.value_a, px.value_b, force_lin ? f_lin : f_wt, p);
        r.linear_value = mix_attr(px.value_a, px.value_b, f_lin, p);
        r.linear_factor = f_lin;
        r.weighted_factor = f_wt;
        r.used_linear = force_lin;
        return r;
    endfunction

    task automatic check_field(string name, logic [DataW-1:0] want, logic [DataW-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            error_count++;
        end
    endtask

    // Input side and random output ready: a pixel stays on the bus until a transfer takes it.
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_valid || in_done)) begin
            if (pending_pixels.size() != 0 && $urandom_range(99) >= idle_pct) begin
                s_tdata <= pending_pixels.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= i_rst_n && ($urandom_range(99) >= idle_pct);
    end

    always @(posedge i_clk) begin
        t_out_s want;
        if (!i_rst_n) begin
            in_done <= 1'b0;
        end else begin
            in_done <= s_valid && o_s_axis_tready;
            if (s_valid && o_s_axis_tready) begin
                awaited_results.push_back(interpolate(s_tdata, edge_mode_cfg));
            end
            if (o_m_axis_tvalid && m_ready) begin
                if (awaited_results.size() == 0) begin
                    $error("Result transfer arrived with no pixel outstanding.");
                    error_count++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("blend_value", want.blend_value, o_m_axis_tdata[31:0]);
                    check_field("linear_value", want.linear_value, o_m_axis_tdata[63:32]);
                    check_field("linear_factor", want.linear_factor, o_m_axis_tdata[95:64]);
                    check_field("weighted_factor", want.weighted_factor,
                                o_m_axis_tdata[127:96]);
                    check_field("used_linear", {31'd0, want.used_linear},
                                {31'd0, o_m_axis_tuser});
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)
                || (pending_pixels.size() == 0 && !s_valid && awaited_results.size() == 0)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= StallLimit) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic add_pixel(logic [15:0] w0, logic [15:0] w1, logic [15:0] pos,
                             logic [15:0] xmin, logic [15:0] xmax,
                             logic [31:0] a, logic [31:0] b);
        t_in_s px;
        px.weight_start = w0;
        px.weight_end = w1;
        px.position = pos;
        px.range_min = xmin;
        px.range_max = xmax;
        px.value_a = a;
        px.value_b = b;
        pending_pixels.push_back(px);
    endtask

    task automatic add_directed_pixels();
        add_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 32'h0, 32'h0);
        add_pixel(16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h7FFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        add_pixel(16'h0100, 16'h0100, 16'd5, 16'd0, 16'd10, 32'd100, 32'd200);
        add_pixel(16'h0001, 16'h0001, 16'd3, 16'd0, 16'd10, 32'd1000, 32'd50);
        add_pixel(16'h0080, 16'h0080, 16'd7, 16'd2, 16'd9, 32'h12345678, 32'h9ABCDEF0);
        add_pixel(16'h0003, 16'h0004, 16'd4, 16'd0, 16'd16, 32'd0, 32'd4096);
        add_pixel(16'h1234, 16'h0F00, 16'd0, 16'd100, 16'hFF9C, 32'd77, 32'd999);
        add_pixel(16'h0040, 16'h0020, 16'd7, 16'd7, 16'd7, 32'd5, 32'd6);
        add_pixel(16'h0010, 16'h0030, 16'd1000, 16'd0, 16'd10, 32'hDEADBEEF, 32'h00C0FFEE);
        add_pixel(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 32'h80000000, 32'h7FFFFFFF);
        add_pixel(16'hFFFF, 16'h0000, 16'd12, 16'hFFF0, 16'd40, 32'hFFFFFFFF, 32'h0);
        add_pixel(16'h5555, 16'h5555, 16'hFFFE, 16'hFF00, 16'h0100, 32'h0, 32'hFFFFFFFF);
    endtask

    task automatic add_random_pixel();
        logic [15:0] w0, w1, xmin, len, pos, xmax;
        int pick;
        w0 = 16'($urandom);
        w1 = 16'($urandom);
        pick = $urandom_range(7);
        if (pick == 0) begin
            w0 = w0 & ~16'h007F;
            w1 = w0;
        end else if (pick == 1) begin
            w0 = (w0 & ~16'h007E) | 16'($urandom_range(1));
            w1 = w0;
        end else if (pick == 2) begin
            w1 = w0;
        end
        if ($urandom_range(99) < 30) begin
            xmin = 16'($urandom);
            xmax = 16'($urandom);
            pos = 16'($urandom);
        end else begin
            xmin = 16'($urandom);
            len = 16'($urandom_range(($urandom_range(3) == 0) ? 4000 : 300));
            xmax = xmin + len;
            pos = xmin + 16'($urandom_range(len));
        end
        add_pixel(w0, w1, pos, xmin, xmax, $urandom, $urandom);
    endtask

    task automatic drain();
        while (pending_pixels.size() != 0 || s_valid) @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic set_precision(logic sel);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= RegPrecision;
        pwdata <= {31'd0, sel};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        edge_mode_cfg = sel;
        @(negedge i_clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field("precision_select", {31'd0, sel}, prdata);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_directed_pixels();
        drain();
        set_precision(1'b1);
        add_directed_pixels();
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            set_precision(phase[0]);
            idle_pct = (phase == 3) ? 0 : 33;
            repeat (225) add_random_pixel();
            drain();
        end

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+design
design/pai_pkg.sv
design/pai_front.sv
design/pai_div_step.sv
design/pai_back.sv
design/perspective_attribute_interpolator.sv
design/pai_checker.sv
tb/sv/tb.sv
